// ===== design/cpbd_pkg.sv =====
// Shared types and constants for the CPU port / ROM bank decoder.
// Used by cpbd_regs, cpbd_decode and cpu_port_rom_bank_decoder_top.
package cpbd_pkg;

  // Result source codes
  localparam logic [2:0] SRC_NONE   = 3'd0;
  localparam logic [2:0] SRC_DIR    = 3'd1;
  localparam logic [2:0] SRC_PORT   = 3'd2;
  localparam logic [2:0] SRC_BASIC  = 3'd3;
  localparam logic [2:0] SRC_CHAR   = 3'd4;
  localparam logic [2:0] SRC_KERNAL = 3'd5;

  // Access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_BASIC_SIZE  = 2'd0;
  localparam logic [1:0] CFG_KERNAL_SIZE = 2'd1;
  localparam logic [1:0] CFG_CHAR_PRESENT = 2'd2;
  localparam logic [1:0] CFG_CHAR_MASK   = 2'd3;

  // Port addresses
  localparam logic [19:0] ADDR_DIR  = 20'h00000;
  localparam logic [19:0] ADDR_PORT = 20'h00001;

  // ROM windows by upper address bits: 0xA000-0xBFFF, 0xD000-0xDFFF, 0xE000-0xFFFF
  localparam logic [6:0] BASIC_BLOCK  = 7'h05;
  localparam logic [7:0] CHAR_PAGE    = 8'h0D;
  localparam logic [6:0] KERNAL_BLOCK = 7'h07;

  // MAP block bits and ROM-select bits
  localparam int MAP_BASIC_BIT  = 5;
  localparam int MAP_CHAR_BIT   = 6;
  localparam int MAP_KERNAL_BIT = 7;
  localparam int RSEL_BASIC_BIT  = 4;
  localparam int RSEL_KERNAL_BIT = 7;

  // Port bank bits
  localparam int LORAM_BIT  = 0;
  localparam int HIRAM_BIT  = 1;
  localparam int CHAREN_BIT = 2;

  // Reset values
  localparam logic [7:0]  DIR_RESET         = 8'h2F;
  localparam logic [7:0]  LATCH_RESET       = 8'h37;
  localparam logic [13:0] ROM_SIZE_RESET    = 14'd8192;
  localparam logic        CHAR_PRESENT_RESET = 1'b1;
  localparam logic [11:0] CHAR_MASK_RESET   = 12'hFFF;

  typedef struct packed {
    logic [13:0] basic_size;
    logic [13:0] kernal_size;
    logic        char_rom_present;
    logic [11:0] char_offset_mask;
  } cfg_t;

  typedef struct packed {
    logic [7:0] direction;
    logic [7:0] latch;
  } port_t;

  typedef struct packed {
    logic        op;
    logic [19:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  rom_select;
    logic [7:0]  map_enables;
  } access_t;

  typedef struct packed {
    logic        claimed;
    logic [2:0]  source;
    logic [12:0] rom_offset;
    logic [7:0]  rdata;
  } result_t;

  typedef struct packed {
    logic       dir_wr;
    logic       latch_wr;
    logic [7:0] data;
  } port_wr_t;

endpackage

// ===== design/cpbd_regs.sv =====
// Configuration registers and the processor port direction/output latches.
// Depends on cpbd_pkg.
module cpbd_regs import cpbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data,
  input  port_wr_t    port_wr,
  output cfg_t        cfg,
  output port_t       port
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.basic_size       <= ROM_SIZE_RESET;
      cfg.kernal_size      <= ROM_SIZE_RESET;
      cfg.char_rom_present <= CHAR_PRESENT_RESET;
      cfg.char_offset_mask <= CHAR_MASK_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_BASIC_SIZE:   cfg.basic_size       <= cfg_data;
        CFG_KERNAL_SIZE:  cfg.kernal_size      <= cfg_data;
        CFG_CHAR_PRESENT: cfg.char_rom_present <= cfg_data[0];
        CFG_CHAR_MASK:    cfg.char_offset_mask <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port.direction <= DIR_RESET;
      port.latch     <= LATCH_RESET;
    end else begin
      if (port_wr.dir_wr) port.direction <= port_wr.data;
      if (port_wr.latch_wr) port.latch <= port_wr.data;
    end
  end

endmodule

// ===== design/cpbd_decode.sv =====
// Address decode for one bus access: port reads/writes and ROM window selection.
// Depends on cpbd_pkg.
module cpbd_decode import cpbd_pkg::*; (
  input  access_t  acc,
  input  cfg_t     cfg,
  input  port_t    port,
  output result_t  res,
  output port_wr_t port_wr
);

  logic [7:0]  eff;
  logic        loram, hiram, charen;
  logic        is_dir, is_port;
  logic        basic_hit, char_hit, kernal_hit;
  logic [12:0] char_off;

  always_comb begin
    // input bits of the port float high
    eff    = (port.latch & port.direction) | ~port.direction;
    loram  = eff[LORAM_BIT];
    hiram  = eff[HIRAM_BIT];
    charen = eff[CHAREN_BIT];

    is_dir  = (acc.addr == ADDR_DIR);
    is_port = (acc.addr == ADDR_PORT);

    // offset below size also rules out an absent ROM
    basic_hit = (acc.addr[19:13] == BASIC_BLOCK) && !acc.map_enables[MAP_BASIC_BIT]
              && (acc.rom_select[RSEL_BASIC_BIT] || (hiram && loram))
              && ({1'b0, acc.addr[12:0]} < cfg.basic_size);
    char_hit = (acc.addr[19:12] == CHAR_PAGE) && hiram && !charen
             && cfg.char_rom_present && !acc.map_enables[MAP_CHAR_BIT];
    kernal_hit = (acc.addr[19:13] == KERNAL_BLOCK) && !acc.map_enables[MAP_KERNAL_BIT]
               && (acc.rom_select[RSEL_KERNAL_BIT] || hiram)
               && ({1'b0, acc.addr[12:0]} < cfg.kernal_size);
    char_off = {1'b0, acc.addr[11:0] & cfg.char_offset_mask};

    port_wr.dir_wr   = (acc.op == OP_WRITE) && is_dir;
    port_wr.latch_wr = (acc.op == OP_WRITE) && is_port;
    port_wr.data     = acc.wdata;

    res = '0;
    if (acc.op == OP_WRITE) begin
      if (is_dir) begin
        res.claimed = 1'b1;
        res.source  = SRC_DIR;
      end else if (is_port) begin
        res.claimed = 1'b1;
        res.source  = SRC_PORT;
      end
    end else if (is_dir) begin
      res.claimed = 1'b1;
      res.source  = SRC_DIR;
      res.rdata   = port.direction;
    end else if (is_port) begin
      res.claimed = 1'b1;
      res.source  = SRC_PORT;
      res.rdata   = eff;
    end else if (basic_hit) begin
      res.claimed    = 1'b1;
      res.source     = SRC_BASIC;
      res.rom_offset = acc.addr[12:0];
    end else if (char_hit) begin
      res.claimed    = 1'b1;
      res.source     = SRC_CHAR;
      res.rom_offset = char_off;
    end else if (kernal_hit) begin
      res.claimed    = 1'b1;
      res.source     = SRC_KERNAL;
      res.rom_offset = acc.addr[12:0];
    end
  end

endmodule

// ===== design/cpu_port_rom_bank_decoder_top.sv =====
// Top level of the CPU port / ROM bank decoder: stream handshake and result register.
// Depends on cpbd_pkg, cpbd_regs and cpbd_decode.

// One bus access is taken per clock while the output is empty or being taken, and its
// result appears in the cycle after from a single result register, which
// also lets a new item in while the held result is being taken in the same
// cycle. Port latch writes take effect for the very next item. Configuration
// writes are always accepted (cfg_ready is high) and should be made while the
// block is idle. Outside the block: the ROM contents, addressed by rom_offset.
module cpu_port_rom_bank_decoder_top import cpbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // addr[19:0], wdata[27:20], rom_select[35:28],
                                      // map_enables[43:36], zero [47:44]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // claimed[0], rom_offset[13:1], rdata[21:14],
                                      // zero [23:22]
  output logic [2:0]  m_axis_tuser,   // source
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  access_t  acc;
  cfg_t     cfg;
  port_t    port;
  result_t  res_next;
  result_t  res;
  port_wr_t dec_wr;
  port_wr_t port_wr;
  logic     accept;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign acc.op          = s_axis_tuser;
  assign acc.addr        = s_axis_tdata[19:0];
  assign acc.wdata       = s_axis_tdata[27:20];
  assign acc.rom_select  = s_axis_tdata[35:28];
  assign acc.map_enables = s_axis_tdata[43:36];

  // latch writes only land with an accepted item
  assign port_wr.dir_wr   = dec_wr.dir_wr && accept;
  assign port_wr.latch_wr = dec_wr.latch_wr && accept;
  assign port_wr.data     = dec_wr.data;

  cpbd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .port_wr   (port_wr),
    .cfg       (cfg),
    .port      (port)
  );

  cpbd_decode u_decode (
    .acc     (acc),
    .cfg     (cfg),
    .port    (port),
    .res     (res_next),
    .port_wr (dec_wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign m_axis_tdata = {2'b00, res.rdata, res.rom_offset, res.claimed};
  assign m_axis_tuser = res.source;

  a_unclaimed_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !res.claimed |->
      res.source == SRC_NONE && res.rom_offset == '0 && res.rdata == '0)
    else $error("unclaimed result carries data");

  a_rdata_port_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.rdata != '0 |-> res.source == SRC_DIR || res.source == SRC_PORT)
    else $error("rdata set for a ROM or empty source");

  a_offset_rom_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.rom_offset != '0 |->
      res.source == SRC_BASIC || res.source == SRC_CHAR || res.source == SRC_KERNAL)
    else $error("rom_offset set for a non-ROM source");

  a_dir_write: assert property (@(posedge clk) disable iff (rst)
    accept && acc.op == OP_WRITE && acc.addr == ADDR_DIR |=> port.direction == $past(acc.wdata))
    else $error("direction latch write lost");

  a_result_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted item produced no result");

endmodule

// ===== tb/cpu_port_rom_bank_decoder_top_tb.sv =====
// Self-checking testbench for cpu_port_rom_bank_decoder_top.
// Predicts each bus access decode in a scoreboard class and checks results in order.
// Depends on cpbd_pkg and the design files under design/.
`timescale 1ns / 100ps

module cpu_port_rom_bank_decoder_top_tb import cpbd_pkg::*; ();

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned NUM_PHASES  = 7;
  localparam int unsigned PHASE_ITEMS = 175;

  // Predicts the decoder: own copy of the port latches and the ROM settings.
  class decoder_scoreboard;
    cfg_t        cfg;
    port_t       port;
    result_t     expected_results[$];
    int unsigned errors;
    int unsigned accesses;
    int unsigned source_hits[6];

    function new();
      cfg.basic_size       = ROM_SIZE_RESET;
      cfg.kernal_size      = ROM_SIZE_RESET;
      cfg.char_rom_present = CHAR_PRESENT_RESET;
      cfg.char_offset_mask = CHAR_MASK_RESET;
      port.direction       = DIR_RESET;
      port.latch           = LATCH_RESET;
      errors   = 0;
      accesses = 0;
      foreach (source_hits[i]) source_hits[i] = 0;
    endfunction

    function void load_register(logic [1:0] index, logic [13:0] data);
      case (index)
        CFG_BASIC_SIZE:   cfg.basic_size = data;
        CFG_KERNAL_SIZE:  cfg.kernal_size = data;
        CFG_CHAR_PRESENT: cfg.char_rom_present = data[0];
        CFG_CHAR_MASK:    cfg.char_offset_mask = data[11:0];
        default: ;
      endcase
    endfunction

    function result_t decode_access(access_t a);
      result_t     r;
      logic [7:0]  p;
      logic        lo, hi, chr;
      logic [19:0] off;
      r = '0;
      if (a.op == OP_WRITE) begin
        if (a.addr == ADDR_DIR) begin
          port.direction = a.wdata;
          r.claimed = 1'b1;
          r.source  = SRC_DIR;
        end else if (a.addr == ADDR_PORT) begin
          port.latch = a.wdata;
          r.claimed = 1'b1;
          r.source  = SRC_PORT;
        end
        return r;
      end
      // input bits of the port float high
      p = (port.latch & port.direction) | ~port.direction;
      if (a.addr == ADDR_DIR) begin
        r.claimed = 1'b1;
        r.source  = SRC_DIR;
        r.rdata   = port.direction;
        return r;
      end
      if (a.addr == ADDR_PORT) begin
        r.claimed = 1'b1;
        r.source  = SRC_PORT;
        r.rdata   = p;
        return r;
      end
      lo  = p[LORAM_BIT];
      hi  = p[HIRAM_BIT];
      chr = p[CHAREN_BIT];
      if (a.addr >= 20'hA000 && a.addr <= 20'hBFFF && cfg.basic_size != 0 &&
          !a.map_enables[MAP_BASIC_BIT] && (a.rom_select[RSEL_BASIC_BIT] || (hi && lo))) begin
        off = a.addr - 20'hA000;
        if (off < {6'b0, cfg.basic_size}) begin
          r.claimed    = 1'b1;
          r.source     = SRC_BASIC;
          r.rom_offset = off[12:0];
          return r;
        end
      end
      if (a.addr >= 20'hD000 && a.addr <= 20'hDFFF && hi && !chr &&
          cfg.char_rom_present && !a.map_enables[MAP_CHAR_BIT]) begin
        off = a.addr - 20'hD000;
        r.claimed    = 1'b1;
        r.source     = SRC_CHAR;
        r.rom_offset = {1'b0, off[11:0] & cfg.char_offset_mask};
        return r;
      end
      if (a.addr >= 20'hE000 && a.addr <= 20'hFFFF && cfg.kernal_size != 0 &&
          !a.map_enables[MAP_KERNAL_BIT] && (a.rom_select[RSEL_KERNAL_BIT] || hi)) begin
        off = a.addr - 20'hE000;
        if (off < {6'b0, cfg.kernal_size}) begin
          r.claimed    = 1'b1;
          r.source     = SRC_KERNAL;
          r.rom_offset = off[12:0];
          return r;
        end
      end
      return r;
    endfunction

    function void note_access(access_t a);
      result_t r;
      r = decode_access(a);
      expected_results.push_back(r);
      accesses++;
      if (r.source <= SRC_KERNAL) source_hits[r.source]++;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: claimed %0d source %0d offset %0d rdata %0d",
                 $time, got.claimed, got.source, got.rom_offset, got.rdata);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.claimed !== want.claimed) begin
        $display("%0t: claimed expected %0d actual %0d", $time, want.claimed, got.claimed);
        errors++;
      end
      if (got.source !== want.source) begin
        $display("%0t: source expected %0d actual %0d", $time, want.source, got.source);
        errors++;
      end
      if (got.rom_offset !== want.rom_offset) begin
        $display("%0t: rom_offset expected %h actual %h", $time, want.rom_offset, got.rom_offset);
        errors++;
      end
      if (got.rdata !== want.rdata) begin
        $display("%0t: rdata expected %h actual %h", $time, want.rdata, got.rdata);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // addr[19:0], wdata[27:20], rom_select[35:28],
                               // map_enables[43:36], zero [47:44]
  logic        s_axis_tuser;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // claimed[0], rom_offset[13:1], rdata[21:14], zero [23:22]
  logic [2:0]  m_axis_tuser;   // source
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [13:0] cfg_data;

  decoder_scoreboard sb;
  bit                hold_request;
  int unsigned       idle_cycles;

  cpu_port_rom_bank_decoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic access_t make_access(logic op, logic [19:0] addr, logic [7:0] wdata,
                                          logic [7:0] rsel, logic [7:0] maps);
    access_t a;
    a.op          = op;
    a.addr        = addr;
    a.wdata       = wdata;
    a.rom_select  = rsel;
    a.map_enables = maps;
    return a;
  endfunction

  // offsets near the loaded size edge hit the below-size check
  function automatic logic [12:0] window_offset(logic [13:0] size);
    logic [13:0] off;
    case ($urandom_range(0, 7))
      0: off = size - 14'd1;
      1: off = size;
      2: off = 14'd0;
      3: off = 14'd8191;
      default: off = 14'($urandom_range(0, 8191));
    endcase
    return off[12:0];
  endfunction

  function automatic access_t random_access(cfg_t c);
    access_t     a;
    int unsigned pick;
    pick          = $urandom_range(0, 99);
    a.op          = ($urandom_range(0, 4) == 0) ? OP_WRITE : OP_READ;
    a.wdata       = 8'($urandom);
    a.rom_select  = 8'($urandom);
    a.map_enables = $urandom_range(0, 1) ? 8'($urandom) : (8'($urandom) & 8'h1F);
    if (pick < 15) begin
      a.op   = OP_WRITE;
      a.addr = $urandom_range(0, 1) ? ADDR_PORT : ADDR_DIR;
    end else if (pick < 25) begin
      a.op   = OP_READ;
      a.addr = $urandom_range(0, 1) ? ADDR_PORT : ADDR_DIR;
    end else if (pick < 45) begin
      a.addr = 20'hA000 + window_offset(c.basic_size);
    end else if (pick < 60) begin
      a.addr = 20'hD000 + 20'($urandom_range(0, 4095));
    end else if (pick < 80) begin
      a.addr = 20'hE000 + window_offset(c.kernal_size);
    end else if (pick < 90) begin
      a.addr = 20'($urandom_range(0, 65535));
    end else begin
      a.addr = 20'($urandom);
    end
    return a;
  endfunction

  task automatic drive_access(access_t a, int unsigned gap);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= a.op;
    s_axis_tdata  <= {4'b0, a.map_enables, a.rom_select, a.wdata, a.addr};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic put_register(logic [1:0] index, logic [13:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_registers(cfg_t c);
    put_register(CFG_BASIC_SIZE, c.basic_size);
    put_register(CFG_KERNAL_SIZE, c.kernal_size);
    put_register(CFG_CHAR_PRESENT, {13'b0, c.char_rom_present});
    put_register(CFG_CHAR_MASK, {2'b0, c.char_offset_mask});
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_directed();
    // reset banking: port reads F7, CHAREN high so character ROM is hidden
    drive_access(make_access(OP_READ, ADDR_DIR, 8'h00, 8'h00, 8'h00), 0);
    drive_access(make_access(OP_READ, ADDR_PORT, 8'hFF, 8'h00, 8'h00), 0);
    drive_access(make_access(OP_READ, 20'h0A000, 8'h00, 8'h00, 8'h00), 0);
    drive_access(make_access(OP_READ, 20'h0BFFF, 8'h00, 8'h00, 8'h00), 1);
    drive_access(make_access(OP_READ, 20'h0D000, 8'h00, 8'h00, 8'h00), 0);
    drive_access(make_access(OP_READ, 20'h0E000, 8'h00, 8'h00, 8'h00), 0);
    drive_access(make_access(OP_READ, 20'h0FFFF, 8'h00, 8'h00, 8'h00), 2);
    drive_access(make_access(OP_READ, 20'hFFFFF, 8'hFF, 8'hFF, 8'h00), 0);
    drive_access(make_access(OP_READ, 20'h10000, 8'h00, 8'h00, 8'h00), 0);
    drive_access(make_access(OP_READ, 20'h10001, 8'h00, 8'h00, 8'h00), 0);
    drive_access(make_access(OP_WRITE, 20'h0A000, 8'h55, 8'h00, 8'h00), 0);
    drive_access(make_access(OP_WRITE, 20'h10001, 8'hAA, 8'h00, 8'h00), 0);
    // all outputs, CHAREN low: character ROM visible unless block 6 is remapped
    drive_access(make_access(OP_WRITE, ADDR_DIR, 8'hFF, 8'h00, 8'h00), 0);
    drive_access(make_access(OP_WRITE, ADDR_PORT, 8'h33, 8'h00, 8'h00), 0);
    drive_access(make_access(OP_READ, 20'h0DFFF, 8'h00, 8'h00, 8'h00), 0);
    drive_access(make_access(OP_READ, 20'h0D000, 8'h00, 8'h00, 8'h40), 0);
    // LORAM and HIRAM low: only the select bits bring the ROMs in
    drive_access(make_access(OP_WRITE, ADDR_PORT, 8'h30, 8'h00, 8'h00), 0);
    drive_access(make_access(OP_READ, 20'h0A000, 8'h00, 8'h10, 8'h00), 0);
    drive_access(make_access(OP_READ, 20'h0E000, 8'h00, 8'h80, 8'h00), 0);
    drive_access(make_access(OP_READ, 20'h0E000, 8'h00, 8'h00, 8'h00), 0);
    drive_access(make_access(OP_READ, 20'h0A000, 8'h00, 8'hFF, 8'hFF), 0);
    // HIRAM only: KERNAL in, BASIC out
    drive_access(make_access(OP_WRITE, ADDR_PORT, 8'h02, 8'h00, 8'h00), 0);
    drive_access(make_access(OP_READ, 20'h0A000, 8'h00, 8'h00, 8'h00), 0);
    drive_access(make_access(OP_READ, 20'h0FFFF, 8'h00, 8'h00, 8'h00), 0);
    // all inputs: port reads back FF whatever the latch holds
    drive_access(make_access(OP_WRITE, ADDR_DIR, 8'h00, 8'h00, 8'h00), 0);
    drive_access(make_access(OP_READ, ADDR_PORT, 8'h00, 8'h00, 8'h00), 0);
  endtask

  // receiver: random ready with runs, one long hold-off on request
  initial begin
    int unsigned run_len, gap;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      repeat (run_len) @(posedge clk);
      gap = pick_gap();
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // monitor and stall watchdog
  always @(posedge clk) begin
    result_t got;
    access_t a;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.claimed    = m_axis_tdata[0];
        got.rom_offset = m_axis_tdata[13:1];
        got.rdata      = m_axis_tdata[21:14];
        got.source     = m_axis_tuser;
        sb.check_result(got);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        a.op          = s_axis_tuser;
        a.addr        = s_axis_tdata[19:0];
        a.wdata       = s_axis_tdata[27:20];
        a.rom_select  = s_axis_tdata[35:28];
        a.map_enables = s_axis_tdata[43:36];
        sb.note_access(a);
      end
      if (cfg_valid && cfg_ready) sb.load_register(cfg_index, cfg_data);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    cfg_t        settings [NUM_PHASES];
    int unsigned gap;
    sb           = new();
    hold_request = 1'b0;
    idle_cycles  = 0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_READ;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_BASIC_SIZE;
    cfg_data      <= '0;
    settings[0] = '{ROM_SIZE_RESET, ROM_SIZE_RESET, CHAR_PRESENT_RESET, CHAR_MASK_RESET};
    settings[1] = '{14'd0, 14'd0, 1'b0, 12'h000};
    settings[2] = '{14'd8192, 14'd8192, 1'b1, 12'hFFF};
    settings[3] = '{14'd1, 14'd1, 1'b1, 12'h000};
    settings[4] = '{14'd16383, 14'd16383, 1'b1, 12'h7FF};
    settings[5] = '{14'd4096, 14'd5000, 1'b0, 12'h3FF};
    settings[6] = '{14'd8191, 14'd1234, 1'b1, 12'hFFF};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        wait_idle();
        write_registers(settings[p]);
        @(posedge clk);
      end
      if (p == 0) run_directed();
      // hold the receiver off while the sender keeps offering
      if (p == 2) hold_request = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ((p == 2 && i < 80) || (p % 2 == 1 && i < 30)) gap = 0;
        else gap = pick_gap();
        drive_access(random_access(sb.cfg), gap);
      end
      s_axis_tvalid <= 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d accesses over %0d ROM settings: port %0d/%0d, BASIC %0d, char %0d,",
             sb.accesses, NUM_PHASES, sb.source_hits[SRC_DIR], sb.source_hits[SRC_PORT],
             sb.source_hits[SRC_BASIC], sb.source_hits[SRC_CHAR]);
    $display("KERNAL %0d, unclaimed %0d; %0d mismatches.", sb.source_hits[SRC_KERNAL],
             sb.source_hits[SRC_NONE], sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
